// File: sv/tss_pkg.sv
// shared types, codes and helpers for the tss window overlap scan block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  // default table capacity
  localparam int unsigned MAX_GENES_DEF = 4096;

  // window length after reset
  localparam logic [19:0] EXT_RESET = 20'd1000;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  // result kinds
  localparam logic RK_QUERY  = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  // report categories
  localparam logic [2:0] CAT_ALL    = 3'd0;
  localparam logic [2:0] CAT_CODING = 3'd1;
  localparam logic [2:0] CAT_PSEUDO = 3'd2;
  localparam logic [2:0] CAT_RNA    = 3'd3;
  localparam logic [2:0] CAT_OTHER  = 3'd4;

  // counter limits
  localparam logic [12:0] CNT13_MAX = 13'h1fff;
  localparam logic [31:0] CNT32_MAX = 32'hffff_ffff;

  // request payload
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  chrom_id;
    logic [27:0] tss_position;
    logic        forward_strand;
    logic [1:0]  gene_kind;
    logic [27:0] site_start;
    logic [27:0] site_end;
  } req_t;

  // result payload
  typedef struct packed {
    logic        result_kind;
    logic        genic;
    logic [11:0] match_index;
    logic [2:0]  category;
    logic [12:0] genes_hit;
    logic [12:0] genes_total;
    logic [31:0] sites_total;
    logic [31:0] sites_genic;
    logic [31:0] sites_intergenic;
    logic        last;
  } rsp_t;

  // one gene record as held in the table
  typedef struct packed {
    logic [7:0]  chrom;
    logic [27:0] tss;
    logic        fwd;
    logic [1:0]  kind;
    logic        hit;
  } rec_t;

  // query bounds, precomputed once per site
  typedef struct packed {
    logic [7:0]         chrom;
    logic [27:0]        s0;        // site start
    logic [27:0]        s1;        // site end
    logic [28:0]        s1_ext;    // site end + window length
    logic signed [28:0] s0_ext;    // site start - window length, may go negative
  } bound_t;

  function automatic logic [12:0] sat13_inc(input logic [12:0] v);
    return (v != CNT13_MAX) ? v + 13'd1 : v;
  endfunction

  function automatic logic [31:0] sat32_inc(input logic [31:0] v);
    return (v != CNT32_MAX) ? v + 32'd1 : v;
  endfunction

  function automatic logic [12:0] sat13_of32(input logic [31:0] v);
    return (v > 32'(CNT13_MAX)) ? CNT13_MAX : v[12:0];
  endfunction

  function automatic logic [11:0] idx12(input logic [31:0] v);
    return v[11:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/tss_gene_table.sv
// gene record table: one write port, one read port with registered data
// depends on tss_pkg for the record type
`timescale 1ns / 1ps
`default_nettype none

module tss_gene_table #(
  parameter int unsigned DEPTH = tss_pkg::MAX_GENES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire tss_pkg::rec_t   wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output tss_pkg::rec_t        rdata_o
);
  import tss_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/tss_window_match.sv
// promoter window overlap test of one table record against a site
// depends on tss_pkg for the record and bound types
`timescale 1ns / 1ps
`default_nettype none

module tss_window_match (
  input  wire tss_pkg::rec_t   rec_i,
  input  wire tss_pkg::bound_t bnd_i,
  output logic                 match_o
);
  import tss_pkg::*;

  logic [28:0]        tss_ext;
  logic signed [28:0] tss_s;
  logic               fwd_ok;
  logic               rev_ok;

  assign tss_ext = {1'b0, rec_i.tss};
  assign tss_s   = $signed(tss_ext);

  // forward: [tss - ext, tss]; tss - ext <= end  <=>  tss <= end + ext
  assign fwd_ok = (tss_ext <= bnd_i.s1_ext) && (rec_i.tss >= bnd_i.s0);

  // reverse: [tss, tss + ext]; tss + ext >= start  <=>  tss >= start - ext
  assign rev_ok = (rec_i.tss <= bnd_i.s1) && (tss_s >= bnd_i.s0_ext);

  assign match_o = (rec_i.chrom == bnd_i.chrom) && (rec_i.fwd ? fwd_ok : rev_ok);

endmodule

`default_nettype wire

// File: sv/tss_window_overlap_scan.sv
// top level: command sequencer, counters and result register around the gene table
// depends on tss_pkg, tss_gene_table and tss_window_match
`timescale 1ns / 1ps
`default_nettype none

// Commands are taken when start is high and busy is low. A load leaves busy low
// and returns nothing. A query keeps busy high while it walks the loaded genes in
// load order, one table read per cycle, stops at the first overlapping window,
// then drives one query result. A report keeps busy high and drives five lines,
// one per cycle. Each result sits on rsp_o for a single cycle with rsp_valid_o
// high; there is no back-pressure, so the receiver must take it then. The window
// length is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block is idle, as the block itself does not enforce it.
module tss_window_overlap_scan #(
  parameter int unsigned MAX_GENES = tss_pkg::MAX_GENES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire tss_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output tss_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_we_i,
  input  wire logic [19:0]   cfg_wdata_i
);
  import tss_pkg::*;

  localparam int unsigned AW    = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_GENES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_REPORT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [19:0]       ext_q;
  bound_t            bnd_q;
  logic [CNT_W-1:0]  issue_q;
  logic              chk_valid_q;
  logic [AW-1:0]     chk_idx_q;
  logic              found_q;
  logic [AW-1:0]     found_idx_q;
  logic [1:0]        found_kind_q;
  logic              new_hit_q;
  logic [12:0]       type_tot_q [4];
  logic [12:0]       type_hit_q [4];
  logic [31:0]       site_q [3];
  logic [2:0]        line_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q;

  logic              accept;
  logic              load_we;
  logic              hit_we;
  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  rec_t              tbl_wdata;
  logic              tbl_re;
  rec_t              rd_rec;
  logic              win_match;
  rec_t              load_rec;
  rec_t              hit_rec;
  logic [31:0]       site_d [3];
  logic [14:0]       hit_sum;
  logic [1:0]        line_type;
  logic [12:0]       rep_hit;
  logic [12:0]       rep_tot;

  assign accept = start && !busy;

  // table write: a load of a new record, or the hit mark of a matched record
  assign load_we = accept && (req_i.command == CMD_LOAD) && (count_q < CNT_W'(MAX_GENES));
  assign hit_we  = (state_q == ST_SCAN) && chk_valid_q && win_match && !rd_rec.hit;

  always_comb begin
    load_rec.chrom = req_i.chrom_id;
    load_rec.tss   = req_i.tss_position;
    load_rec.fwd   = req_i.forward_strand;
    load_rec.kind  = req_i.gene_kind;
    load_rec.hit   = 1'b0;
    hit_rec        = rd_rec;
    hit_rec.hit    = 1'b1;
  end

  assign tbl_we    = load_we || hit_we;
  assign tbl_waddr = load_we ? count_q[AW-1:0] : chk_idx_q;
  assign tbl_wdata = load_we ? load_rec : hit_rec;

  // scan read: one entry per cycle until every loaded gene is issued or a match ends the scan
  assign tbl_re = (state_q == ST_SCAN) && (issue_q < count_q);

  tss_gene_table #(
    .DEPTH (MAX_GENES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_rec)
  );

  tss_window_match u_match (
    .rec_i   (rd_rec),
    .bnd_i   (bnd_q),
    .match_o (win_match)
  );

  // site counters after the query in flight
  always_comb begin
    site_d[0] = sat32_inc(site_q[0]);
    site_d[1] = found_q ? sat32_inc(site_q[1]) : site_q[1];
    site_d[2] = found_q ? site_q[2] : sat32_inc(site_q[2]);
  end

  // report line selection
  assign hit_sum   = 15'(type_hit_q[0]) + 15'(type_hit_q[1])
                   + 15'(type_hit_q[2]) + 15'(type_hit_q[3]);
  assign line_type = 2'(line_q - 3'd1);

  always_comb begin
    if (line_q == CAT_ALL) begin
      rep_hit = sat13_of32(32'(hit_sum));
      rep_tot = sat13_of32(32'(count_q));
    end else begin
      rep_hit = type_hit_q[line_type];
      rep_tot = type_tot_q[line_type];
    end
  end

  // sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ext_q        <= EXT_RESET;
      bnd_q        <= '0;
      issue_q      <= '0;
      chk_valid_q  <= 1'b0;
      chk_idx_q    <= '0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      found_kind_q <= '0;
      new_hit_q    <= 1'b0;
      line_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
      for (int i = 0; i < 4; i++) begin
        type_tot_q[i] <= '0;
        type_hit_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        site_q[i] <= '0;
      end
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_we_i) begin
        ext_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_i.command)
              CMD_LOAD: begin
                if (load_we) begin
                  count_q                      <= count_q + CNT_W'(1);
                  type_tot_q[req_i.gene_kind]  <= sat13_inc(type_tot_q[req_i.gene_kind]);
                end
              end
              CMD_QUERY: begin
                bnd_q.chrom  <= req_i.chrom_id;
                bnd_q.s0     <= req_i.site_start;
                bnd_q.s1     <= req_i.site_end;
                bnd_q.s1_ext <= {1'b0, req_i.site_end} + 29'(ext_q);
                bnd_q.s0_ext <= $signed({1'b0, req_i.site_start} - 29'(ext_q));
                issue_q      <= '0;
                chk_valid_q  <= 1'b0;
                state_q      <= ST_SCAN;
              end
              CMD_REPORT: begin
                line_q  <= CAT_ALL;
                state_q <= ST_REPORT;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          chk_valid_q <= tbl_re;
          chk_idx_q   <= issue_q[AW-1:0];
          if (tbl_re) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          if (chk_valid_q && win_match) begin
            found_q      <= 1'b1;
            found_idx_q  <= chk_idx_q;
            found_kind_q <= rd_rec.kind;
            new_hit_q    <= !rd_rec.hit;
            state_q      <= ST_FINISH;
          end else if (!chk_valid_q && !tbl_re) begin
            found_q     <= 1'b0;
            found_idx_q <= '0;
            new_hit_q   <= 1'b0;
            state_q     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          for (int i = 0; i < 3; i++) begin
            site_q[i] <= site_d[i];
          end
          if (new_hit_q) begin
            type_hit_q[found_kind_q] <= sat13_inc(type_hit_q[found_kind_q]);
          end
          rsp_valid_q            <= 1'b1;
          rsp_q.result_kind      <= RK_QUERY;
          rsp_q.genic            <= found_q;
          rsp_q.match_index      <= idx12(32'(found_idx_q));
          rsp_q.category         <= CAT_ALL;
          rsp_q.genes_hit        <= '0;
          rsp_q.genes_total      <= '0;
          rsp_q.sites_total      <= site_d[0];
          rsp_q.sites_genic      <= site_d[1];
          rsp_q.sites_intergenic <= site_d[2];
          rsp_q.last             <= 1'b1;
          state_q                <= ST_IDLE;
        end
        ST_REPORT: begin
          rsp_valid_q            <= 1'b1;
          rsp_q.result_kind      <= RK_REPORT;
          rsp_q.genic            <= 1'b0;
          rsp_q.match_index      <= '0;
          rsp_q.category         <= line_q;
          rsp_q.genes_hit        <= rep_hit;
          rsp_q.genes_total      <= rep_tot;
          rsp_q.sites_total      <= site_q[0];
          rsp_q.sites_genic      <= site_q[1];
          rsp_q.sites_intergenic <= site_q[2];
          rsp_q.last             <= (line_q == CAT_OTHER);
          line_q                 <= line_q + 3'd1;
          if (line_q == CAT_OTHER) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // a result only follows a busy cycle
  a_rsp_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> $past(busy))
    else $error("result strobe without preceding work");

  // until saturation every site is either genic or intergenic
  a_site_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (site_q[0] != CNT32_MAX) |->
      (33'(site_q[0]) == 33'(site_q[1]) + 33'(site_q[2])))
    else $error("site counters out of balance");

  // a category never has more hit genes than loaded genes
  a_hits_le_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (type_hit_q[0] <= type_tot_q[0]) && (type_hit_q[1] <= type_tot_q[1]) &&
    (type_hit_q[2] <= type_tot_q[2]) && (type_hit_q[3] <= type_tot_q[3]))
    else $error("gene hit count exceeds loaded count");

  // a hit mark is written back only inside the loaded range and never together with a load
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_we |-> (CNT_W'(chk_idx_q) < count_q) && !load_we)
    else $error("hit write-back outside loaded range");

  // the last report line is the final category
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.result_kind == RK_REPORT) && rsp_q.last) |->
      (rsp_q.category == CAT_OTHER))
    else $error("report ended on wrong category");

endmodule

`default_nettype wire

// File: tb/tb_tss_window_overlap_scan.sv
// self-checking testbench for tss_window_overlap_scan: loads, site queries and reports
// depends on tss_pkg and the tss_window_overlap_scan rtl
`timescale 1ns / 1ps

module tb_tss_window_overlap_scan;
  import tss_pkg::*;

  // small table so the full-table drop path is reached
  localparam int unsigned GENE_CAP = 64;
  localparam logic [27:0] POS_MAX = 28'hfff_ffff;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PER_PHASE = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        rsp_valid_o;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  logic [19:0] cfg_wdata_i;

  // gene table copy, counters and the answers still owed by the block
  class window_scan_scoreboard;
    logic [7:0]  g_chrom [GENE_CAP];
    logic [27:0] g_tss   [GENE_CAP];
    logic        g_fwd   [GENE_CAP];
    logic [1:0]  g_kind  [GENE_CAP];
    logic        g_hit   [GENE_CAP];
    int unsigned n_genes;
    logic [12:0] kind_total [4];
    logic [12:0] kind_hits  [4];
    logic [31:0] n_sites;
    logic [31:0] n_genic;
    logic [31:0] n_intergenic;
    logic [19:0] window_len;
    rsp_t        answers_due [$];
    int unsigned errors;

    function new();
      n_genes = 0;
      foreach (kind_total[k]) begin
        kind_total[k] = '0;
        kind_hits[k]  = '0;
      end
      n_sites      = '0;
      n_genic      = '0;
      n_intergenic = '0;
      window_len   = EXT_RESET;
      errors       = 0;
    endfunction

    // work out what an accepted request must produce
    function void record_request(req_t r);
      rsp_t        a;
      longint      s0, s1, lo, hi, t, ext;
      int          hit_at;
      int unsigned all_hit, all_tot;
      case (r.command)
        CMD_LOAD: begin
          if (n_genes < GENE_CAP) begin
            g_chrom[n_genes] = r.chrom_id;
            g_tss[n_genes]   = r.tss_position;
            g_fwd[n_genes]   = r.forward_strand;
            g_kind[n_genes]  = r.gene_kind;
            g_hit[n_genes]   = 1'b0;
            n_genes++;
            if (kind_total[r.gene_kind] != 13'h1fff)
              kind_total[r.gene_kind] = kind_total[r.gene_kind] + 13'd1;
          end
        end
        CMD_QUERY: begin
          s0 = longint'(r.site_start);
          s1 = longint'(r.site_end);
          ext = longint'(window_len);
          hit_at = -1;
          // first window on the same chromosome that overlaps the site
          for (int j = 0; j < int'(n_genes) && hit_at < 0; j++) begin
            if (g_chrom[j] == r.chrom_id) begin
              t = longint'(g_tss[j]);
              lo = g_fwd[j] ? t - ext : t;
              hi = g_fwd[j] ? t : t + ext;
              if (lo <= s1 && hi >= s0) hit_at = j;
            end
          end
          if (hit_at >= 0 && !g_hit[hit_at]) begin
            g_hit[hit_at] = 1'b1;
            if (kind_hits[g_kind[hit_at]] != 13'h1fff)
              kind_hits[g_kind[hit_at]] = kind_hits[g_kind[hit_at]] + 13'd1;
          end
          if (n_sites != 32'hffff_ffff) n_sites++;
          if (hit_at >= 0) begin
            if (n_genic != 32'hffff_ffff) n_genic++;
          end else begin
            if (n_intergenic != 32'hffff_ffff) n_intergenic++;
          end
          a = '0;
          a.result_kind      = RK_QUERY;
          a.genic            = (hit_at >= 0);
          a.match_index      = (hit_at >= 0) ? 12'(hit_at) : 12'd0;
          a.sites_total      = n_sites;
          a.sites_genic      = n_genic;
          a.sites_intergenic = n_intergenic;
          a.last             = 1'b1;
          answers_due.push_back(a);
        end
        CMD_REPORT: begin
          all_hit = 0;
          foreach (kind_hits[k]) all_hit += kind_hits[k];
          if (all_hit > 8191) all_hit = 8191;
          all_tot = (n_genes > 8191) ? 8191 : n_genes;
          a = '0;
          a.result_kind      = RK_REPORT;
          a.category         = CAT_ALL;
          a.genes_hit        = 13'(all_hit);
          a.genes_total      = 13'(all_tot);
          a.sites_total      = n_sites;
          a.sites_genic      = n_genic;
          a.sites_intergenic = n_intergenic;
          answers_due.push_back(a);
          // one line per gene kind, the last one closes the report
          for (int k = 0; k < 4; k++) begin
            a.category    = CAT_CODING + 3'(k);
            a.genes_hit   = kind_hits[k];
            a.genes_total = kind_total[k];
            a.last        = (k == 3);
            answers_due.push_back(a);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_answer(rsp_t got);
      rsp_t want;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = answers_due.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("genic", want.genic, got.genic);
      compare_field("match_index", want.match_index, got.match_index);
      compare_field("category", want.category, got.category);
      compare_field("genes_hit", want.genes_hit, got.genes_hit);
      compare_field("genes_total", want.genes_total, got.genes_total);
      compare_field("sites_total", want.sites_total, got.sites_total);
      compare_field("sites_genic", want.sites_genic, got.sites_genic);
      compare_field("sites_intergenic", want.sites_intergenic, got.sites_intergenic);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  window_scan_scoreboard sb = new();

  tss_window_overlap_scan #(
    .MAX_GENES(GENE_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // monitor: results first, then register writes, then new requests
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (rsp_valid_o === 1'b1) sb.check_answer(rsp_o);
      if (cfg_we_i === 1'b1) sb.window_len = cfg_wdata_i;
      if (start === 1'b1 && busy === 1'b0) sb.record_request(req_i);
    end
  end

  // request with every field set, the unused ones random
  function automatic req_t make_request(logic [1:0] cmd, logic [7:0] chrom, logic [27:0] tss,
                                        logic fwd, logic [1:0] kind, logic [27:0] s0,
                                        logic [27:0] s1);
    req_t r;
    r.command        = cmd;
    r.chrom_id       = chrom;
    r.tss_position   = (cmd == CMD_LOAD) ? tss : 28'($urandom);
    r.forward_strand = (cmd == CMD_LOAD) ? fwd : 1'($urandom);
    r.gene_kind      = (cmd == CMD_LOAD) ? kind : 2'($urandom);
    r.site_start     = (cmd == CMD_QUERY) ? s0 : 28'($urandom);
    r.site_end       = (cmd == CMD_QUERY) ? s1 : 28'($urandom);
    return r;
  endfunction

  function automatic logic [27:0] clamp_pos(longint v);
    if (v < 0) return 28'd0;
    if (v > longint'(POS_MAX)) return POS_MAX;
    return 28'(v);
  endfunction

  // random request: mostly loads and queries aimed at loaded windows
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick, j;
    logic [7:0]  chrom;
    logic [27:0] tss, s0, s1, swap;
    longint      ext, lo;
    pick  = $urandom_range(0, 99);
    chrom = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    tss = 28'($urandom);
      2:       tss = 28'($urandom_range(0, 2000));
      default: tss = 28'($urandom_range(0, 200000));
    endcase
    if (pick < 45) begin
      r = make_request(CMD_LOAD, chrom, tss, 1'($urandom), 2'($urandom), '0, '0);
    end else if (pick < 90) begin
      if (sb.n_genes > 0 && $urandom_range(0, 9) < 7) begin
        // site placed around the window of a loaded gene
        j     = $urandom_range(0, sb.n_genes - 1);
        chrom = sb.g_chrom[j];
        ext   = longint'(sb.window_len);
        lo    = longint'(sb.g_tss[j]) - ext - 100
              + longint'($urandom_range(0, 2 * sb.window_len + 200));
        s0    = clamp_pos(lo);
        s1    = clamp_pos(lo + longint'($urandom_range(0, 400)));
      end else if ($urandom_range(0, 1) == 0) begin
        s0 = 28'($urandom);
        s1 = 28'($urandom);
      end else begin
        s0 = 28'($urandom_range(0, 200000));
        s1 = s0 + 28'($urandom_range(0, 5000));
      end
      // occasional reversed site
      if ($urandom_range(0, 9) == 0) begin
        swap = s0;
        s0   = s1;
        s1   = swap;
      end
      r = make_request(CMD_QUERY, chrom, '0, 1'b0, '0, s0, s1);
    end else if (pick < 97) begin
      r = make_request(CMD_REPORT, chrom, '0, 1'b0, '0, '0, '0);
    end else begin
      r = make_request(CMD_UNUSED, chrom, '0, 1'b0, '0, '0, '0);
    end
    return r;
  endfunction

  // drive one request from a falling edge and hold it until taken
  task automatic send_request(req_t r, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
  endtask

  // drop start and wait for every answer plus the tail of any load
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.answers_due.size() != 0 || busy !== 1'b0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_window(logic [19:0] len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [19:0] phase_window [4];
    int unsigned gap;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, window edges, extremes, reversed sites
    send_request(make_request(CMD_REPORT, 8'd0, '0, 1'b0, '0, '0, '0), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd100, 28'd200), 0);
    send_request(make_request(CMD_LOAD, 8'd0, 28'd0, 1'b1, 2'd0, '0, '0), 0);
    send_request(make_request(CMD_LOAD, 8'd255, POS_MAX, 1'b0, 2'd3, '0, '0), 0);
    send_request(make_request(CMD_LOAD, 8'd1, 28'd5000, 1'b1, 2'd1, '0, '0), 0);
    send_request(make_request(CMD_LOAD, 8'd1, 28'd5000, 1'b0, 2'd2, '0, '0), 0);
    send_request(make_request(CMD_UNUSED, 8'($urandom), '0, 1'b0, '0, '0, '0), 0);
    send_request(make_request(CMD_QUERY, 8'd0, '0, 1'b0, '0, 28'd0, 28'd0), 0);
    send_request(make_request(CMD_QUERY, 8'd0, '0, 1'b0, '0, 28'd0, POS_MAX), 0);
    send_request(make_request(CMD_QUERY, 8'd255, '0, 1'b0, '0, POS_MAX, POS_MAX), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd3000, 28'd3999), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd3000, 28'd4000), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd6000, 28'd9000), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd6001, 28'd9000), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd7000, 28'd4500), 0);
    send_request(make_request(CMD_QUERY, 8'd1, '0, 1'b0, '0, 28'd5000, 28'd4900), 0);
    send_request(make_request(CMD_QUERY, 8'd2, '0, 1'b0, '0, 28'd0, POS_MAX), 0);
    send_request(make_request(CMD_LOAD, 8'd1, 28'd0, 1'b0, 2'd3, '0, '0), 0);
    send_request(make_request(CMD_REPORT, 8'd0, '0, 1'b0, '0, '0, '0), 0);

    // random phases at several window lengths, no idling in the last one
    phase_window[0] = 20'd0;
    phase_window[1] = 20'hf_ffff;
    phase_window[2] = 20'($urandom_range(2, 100000));
    phase_window[3] = 20'd1;
    for (int p = 0; p < 4; p++) begin
      write_window(phase_window[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        gap = 0;
        if (p != 3 && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 9);
        send_request(random_request(), gap);
      end
    end
    send_request(make_request(CMD_REPORT, 8'd0, '0, 1'b0, '0, '0, '0), 0);
    wait_idle();

    if (sb.errors == 0 && sb.answers_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
sv/tss_pkg.sv
sv/tss_gene_table.sv
sv/tss_window_match.sv
sv/tss_window_overlap_scan.sv
tb/tb_tss_window_overlap_scan.sv
